### rtl/core/sv39_page_table_walker_defines.svh
// Assertion macros shared by the Sv39 page-table walker RTL.
`ifndef SV39_PAGE_TABLE_WALKER_DEFINES_SVH
`define SV39_PAGE_TABLE_WALKER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define SV39PTW_ASSERT_IMPL(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define SV39PTW_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);

`endif

### rtl/core/sv39ptw_pkg.sv
// Types and constants shared by the Sv39 page-table walker modules.
package sv39ptw_pkg;

	// Fixed geometry of Sv39 tables and of the payload fields.
	localparam int ENTRIES_PER_PAGE = 512;
	localparam int VPN_W            = 9;
	localparam int SV39_VA_W        = 39;
	localparam int MAXVA_BITS       = 38;
	localparam int PPN_W            = 44;
	localparam int OFFSET_W         = 12;
	localparam int PADDR_W          = 56;
	localparam int PTE_W            = 64;
	localparam int ENTRY_INDEX_W    = 13;
	localparam int CFG_DATA_W       = 44;
	localparam int ROOT_W           = 4;
	localparam int QUEUE_DEPTH      = 2;

	// PTE bit positions.
	localparam int PTE_V_BIT   = 0;
	localparam int PTE_U_BIT   = 4;
	localparam int PTE_PPN_LSB = 10;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		CFG_ROOT_TABLE_PAGE = 1'b0,
		CFG_WINDOW_BASE_PPN = 1'b1
	} cfg_reg_t;

	// Fault codes reported with each result.
	typedef enum logic [2:0] {
		FK_NONE         = 3'd0,
		FK_VA_RANGE     = 3'd1,
		FK_PTR_INVALID  = 3'd2,
		FK_LEAF_INVALID = 3'd3,
		FK_NOT_USER     = 3'd4,
		FK_OUTSIDE      = 3'd5
	} fault_kind_t;

	// Work handed from the front end to the back end.
	typedef enum logic [1:0] {
		JOB_WRITE = 2'd0,
		JOB_WALK  = 2'd1,
		JOB_REPLY = 2'd2
	} job_kind_t;

	typedef struct packed {
		job_kind_t                 kind;
		fault_kind_t               reply_kind;
		logic [SV39_VA_W-1:0]      vaddr;
		logic [ENTRY_INDEX_W-1:0]  entry_index;
		logic [PTE_W-1:0]          entry_value;
	} job_t;

	// One result transaction.
	typedef struct packed {
		logic [PADDR_W-1:0] paddr;
		logic               fault;
		fault_kind_t        fault_kind;
	} result_t;

	// Back-end walk sequencer.
	typedef enum logic [2:0] {
		BK_CLEAR = 3'd0,
		BK_IDLE  = 3'd1,
		BK_L2    = 3'd2,
		BK_L1    = 3'd3,
		BK_L0    = 3'd4
	} bk_state_t;

endpackage

### rtl/core/sv39ptw_req_if.sv
// Request channel: PTE writes and translation requests.
interface sv39ptw_req_if;
	logic        valid;
	logic        ready;
	logic        cmd;
	logic [63:0] vaddr;
	logic [12:0] entry_index;
	logic [63:0] entry_value;

	modport source (output valid, output cmd, output vaddr, output entry_index,
		output entry_value, input ready);
	modport sink (input valid, input cmd, input vaddr, input entry_index,
		input entry_value, output ready);
endinterface

### rtl/core/sv39ptw_rsp_if.sv
// Response channel: translated address and fault code.
interface sv39ptw_rsp_if;
	logic        valid;
	logic        ready;
	logic [55:0] paddr;
	logic        fault;
	logic [2:0]  fault_kind;

	modport source (output valid, output paddr, output fault, output fault_kind,
		input ready);
	modport sink (input valid, input paddr, input fault, input fault_kind,
		output ready);
endinterface

### rtl/core/sv39ptw_front.sv
// Front end: accepts request transactions and classifies them into jobs.
module sv39ptw_front #(
	parameter int TABLE_PAGES = 16
) (
	sv39ptw_req_if.sink                     req,
	input  logic                            clr_busy,
	input  logic [sv39ptw_pkg::ROOT_W-1:0]  cfg_root,
	output logic                            push_valid,
	input  logic                            push_ready,
	output sv39ptw_pkg::job_t               push_job
);
	import sv39ptw_pkg::*;

	localparam int MEM_WORDS = TABLE_PAGES * ENTRIES_PER_PAGE;

	// Requests wait while the table store is being cleared.
	assign req.ready  = push_ready && !clr_busy;
	assign push_valid = req.valid && !clr_busy;

	// Early checks that need no table access become immediate replies.
	always_comb begin
		push_job             = '0;
		push_job.vaddr       = req.vaddr[SV39_VA_W-1:0];
		push_job.entry_index = req.entry_index;
		push_job.entry_value = req.entry_value;
		push_job.reply_kind  = FK_NONE;
		if (req.cmd) begin
			if (req.vaddr[63:MAXVA_BITS] != '0) begin
				push_job.kind       = JOB_REPLY;
				push_job.reply_kind = FK_VA_RANGE;
			end else if (int'(cfg_root) >= TABLE_PAGES) begin
				push_job.kind       = JOB_REPLY;
				push_job.reply_kind = FK_OUTSIDE;
			end else begin
				push_job.kind = JOB_WALK;
			end
		end else if (int'(req.entry_index) < MEM_WORDS) begin
			push_job.kind = JOB_WRITE;
		end else begin
			// A write beyond the store is dropped and answered with zeros.
			push_job.kind = JOB_REPLY;
		end
	end
endmodule

### rtl/core/sv39ptw_queue.sv
// Short job queue between the front end and the back end.
module sv39ptw_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push_valid,
	output logic               push_ready,
	input  sv39ptw_pkg::job_t  push_job,
	output logic               pop_valid,
	input  logic               pop_ready,
	output sv39ptw_pkg::job_t  pop_job
);
	import sv39ptw_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	job_t             slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != CNT_W'(QUEUE_DEPTH));
	assign pop_valid  = (count_q != '0);
	assign pop_job    = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage slots.
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_job;
		end
	end
endmodule

### rtl/core/sv39ptw_back.sv
// Back end: table store, clearing pass, walk sequencer and result register.
module sv39ptw_back #(
	parameter int TABLE_PAGES = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [sv39ptw_pkg::ROOT_W-1:0]    cfg_root,
	input  logic [sv39ptw_pkg::PPN_W-1:0]     cfg_base,
	input  logic                              pop_valid,
	output logic                              pop_ready,
	input  sv39ptw_pkg::job_t                 pop_job,
	output logic                              clr_busy,
	sv39ptw_rsp_if.source                     rsp
);
	import sv39ptw_pkg::*;

	localparam int MEM_WORDS = TABLE_PAGES * ENTRIES_PER_PAGE;
	localparam int ADDR_W    = $clog2(MEM_WORDS);
	localparam int PAGE_W    = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;

	bk_state_t             state_q;
	bk_state_t             state_d;
	logic [ADDR_W-1:0]     clr_q;
	logic [SV39_VA_W-1:0]  vaddr_q;
	logic [PTE_W-1:0]      mem_q [MEM_WORDS];
	logic [PTE_W-1:0]      rdata_q;
	logic                  out_valid_q;
	result_t               out_q;

	logic                  mem_we;
	logic [ADDR_W-1:0]     mem_waddr;
	logic [PTE_W-1:0]      mem_wdata;
	logic                  mem_re;
	logic [ADDR_W-1:0]     mem_raddr;
	logic                  res_load;
	result_t               res_d;
	logic                  out_free;
	logic                  clr_last;
	logic                  pte_v;
	logic                  pte_u;
	logic [PPN_W-1:0]      pte_ppn;
	logic [PPN_W:0]        ppn_diff;
	logic                  in_window;
	logic [PAGE_W-1:0]     next_page;
	logic                  ptr_ok;

	assign out_free = !out_valid_q || rsp.ready;
	assign clr_last = (clr_q == ADDR_W'(MEM_WORDS - 1));
	assign clr_busy = (state_q == BK_CLEAR);

	// Decode of the entry just read and its window check.
	assign pte_v     = rdata_q[PTE_V_BIT];
	assign pte_u     = rdata_q[PTE_U_BIT];
	assign pte_ppn   = rdata_q[PTE_PPN_LSB +: PPN_W];
	assign ppn_diff  = {1'b0, pte_ppn} - {1'b0, cfg_base};
	assign in_window = !ppn_diff[PPN_W] && (ppn_diff[PPN_W-1:0] < PPN_W'(TABLE_PAGES));
	assign next_page = ppn_diff[PAGE_W-1:0];
	assign ptr_ok    = pte_v && in_window;

	// Next-state logic of the walk sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_CLEAR: begin
				if (clr_last) begin
					state_d = BK_IDLE;
				end
			end
			BK_IDLE: begin
				if (pop_valid && out_free && pop_job.kind == JOB_WALK) begin
					state_d = BK_L2;
				end
			end
			BK_L2: begin
				if (ptr_ok) begin
					state_d = BK_L1;
				end else if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			BK_L1: begin
				if (ptr_ok) begin
					state_d = BK_L0;
				end else if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			BK_L0: begin
				if (out_free) begin
					state_d = BK_IDLE;
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	// Output logic of the walk sequencer.
	always_comb begin
		pop_ready = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = clr_q;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		res_load  = 1'b0;
		res_d     = '0;
		case (state_q)
			BK_CLEAR: begin
				mem_we = 1'b1;
			end
			BK_IDLE: begin
				pop_ready = out_free;
				if (pop_valid && out_free) begin
					case (pop_job.kind)
						JOB_WRITE: begin
							mem_we    = 1'b1;
							mem_waddr = ADDR_W'(pop_job.entry_index);
							mem_wdata = pop_job.entry_value;
							res_load  = 1'b1;
						end
						JOB_WALK: begin
							mem_re    = 1'b1;
							mem_raddr = ADDR_W'({PAGE_W'(cfg_root),
								pop_job.vaddr[OFFSET_W + 2*VPN_W +: VPN_W]});
						end
						default: begin
							res_load         = 1'b1;
							res_d.fault      = (pop_job.reply_kind != FK_NONE);
							res_d.fault_kind = pop_job.reply_kind;
						end
					endcase
				end
			end
			BK_L2, BK_L1: begin
				if (ptr_ok) begin
					mem_re = 1'b1;
					if (state_q == BK_L2) begin
						mem_raddr = ADDR_W'({next_page, vaddr_q[OFFSET_W + VPN_W +: VPN_W]});
					end else begin
						mem_raddr = ADDR_W'({next_page, vaddr_q[OFFSET_W +: VPN_W]});
					end
				end else begin
					res_load         = out_free;
					res_d.fault      = 1'b1;
					res_d.fault_kind = pte_v ? FK_OUTSIDE : FK_PTR_INVALID;
				end
			end
			BK_L0: begin
				res_load = out_free;
				if (!pte_v) begin
					res_d.fault      = 1'b1;
					res_d.fault_kind = FK_LEAF_INVALID;
				end else if (!pte_u) begin
					res_d.fault      = 1'b1;
					res_d.fault_kind = FK_NOT_USER;
				end else begin
					res_d.paddr = {pte_ppn, vaddr_q[OFFSET_W-1:0]};
				end
			end
			default: begin
				res_d = '0;
			end
		endcase
	end

	// Sequencer state, clearing counter and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == BK_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Walk operand and result payload.
	always_ff @(posedge clk) begin
		if (pop_valid && pop_ready) begin
			vaddr_q <= pop_job.vaddr;
		end
		if (res_load) begin
			out_q <= res_d;
		end
	end

	// Table store: one write port and one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem_q[mem_raddr];
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.paddr      = out_q.paddr;
	assign rsp.fault      = out_q.fault;
	assign rsp.fault_kind = out_q.fault_kind;
endmodule

### rtl/core/sv39_page_table_walker.sv
// Top level of the Sv39 page-table walker.
//
//   Port      Direction  Payload                                   Transaction
//   req       in         cmd, vaddr, entry_index, entry_value      valid & ready
//   rsp       out        paddr, fault, fault_kind                  valid & ready
//   cfg_*     in         cfg_index, cfg_wdata                      cfg_we
//
// A translation in the back end makes three dependent reads of the table memory,
// then loads the result register.
// A PTE write, or a request that fails its early checks, loads the result register directly.
// After reset a clearing pass zeroes the table memory, one word a cycle, and
// req.ready stays low meanwhile.
// A two-entry job queue lets requests be taken while the back end is busy or
// a result waits on rsp.ready.
`include "sv39_page_table_walker_defines.svh"

module sv39_page_table_walker #(
	parameter int TABLE_PAGES = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [0:0]                           cfg_index,
	input  logic [sv39ptw_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	sv39ptw_req_if.sink                          req,
	sv39ptw_rsp_if.source                        rsp
);
	import sv39ptw_pkg::*;

	logic [ROOT_W-1:0] root_q;
	logic [PPN_W-1:0]  base_q;
	logic              clr_busy;
	logic              push_valid;
	logic              push_ready;
	job_t              push_job;
	logic              pop_valid;
	logic              pop_ready;
	job_t              pop_job;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= '0;
			base_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_ROOT_TABLE_PAGE: root_q <= cfg_wdata[ROOT_W-1:0];
				CFG_WINDOW_BASE_PPN: base_q <= cfg_wdata[PPN_W-1:0];
				default: begin
					root_q <= root_q;
				end
			endcase
		end
	end

	sv39ptw_front #(
		.TABLE_PAGES (TABLE_PAGES)
	) u_front (
		.req        (req),
		.clr_busy   (clr_busy),
		.cfg_root   (root_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	sv39ptw_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	sv39ptw_back #(
		.TABLE_PAGES (TABLE_PAGES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_root  (root_q),
		.cfg_base  (base_q),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job),
		.clr_busy  (clr_busy),
		.rsp       (rsp)
	);

	// No request is taken while the table memory is being cleared.
	`SV39PTW_ASSERT_IMPL(a_no_req_in_clear, clr_busy, !req.ready, "request accepted during clear")
	// The clearing pass runs once after reset.
	`SV39PTW_ASSERT_NEXT(a_clear_once, !clr_busy, !clr_busy, "clearing pass restarted")
	// The fault flag agrees with the fault code.
	`SV39PTW_ASSERT_IMPL(a_fault_flag, rsp.valid,
		rsp.fault == (rsp.fault_kind != FK_NONE), "fault flag and code disagree")
	// A failed translation returns a zero address.
	`SV39PTW_ASSERT_IMPL(a_fault_zero, rsp.valid && rsp.fault, rsp.paddr == '0,
		"faulting result with nonzero address")
endmodule
